/* src/ldbr_pkg.sv */
package ldbr_pkg;

    localparam int MODE_W    = 2;
    localparam int Z_W       = 32;
    localparam int RADIUS_W  = 31;
    localparam int IDX_W     = 16;
    localparam int SEL_W     = 10;
    localparam int DEPTH_W   = 32;
    localparam int BIN_IDX_W = 16;   // holds any bin number up to the largest table
    localparam int ENTRY_W   = 2 * IDX_W;

    localparam logic [IDX_W-1:0]   EMPTY_MIN       = 16'hFFFF;
    localparam logic [IDX_W-1:0]   EMPTY_MAX       = 16'h0000;
    localparam logic [ENTRY_W-1:0] BIN_EMPTY       = 32'hFFFF0000;
    localparam logic [DEPTH_W-1:0] BIN_DEPTH_RESET = 32'd65536;

    // Register index as decoded from the configuration address.
    localparam logic REG_BIN_DEPTH = 1'b0;

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;
    localparam int CMDQ_CNT_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                op;
        logic [BIN_IDX_W-1:0] lo;
        logic [BIN_IDX_W-1:0] hi;
        logic [IDX_W-1:0]     idx;
        logic [SEL_W-1:0]     sel;
    } cmd_t;

    typedef enum logic {
        F_IDLE,
        F_DIV
    } front_state_t;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_CLEAR,
        B_WALK,
        B_DONE
    } back_state_t;

endpackage

/* src/ldbr_ram.sv */
module ldbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/ldbr_div.sv */
module ldbr_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [ldbr_pkg::DEPTH_W-1:0]  dividend,
    input  logic [ldbr_pkg::DEPTH_W-1:0]  divisor,
    output logic                          busy,
    output logic [ldbr_pkg::DEPTH_W-1:0]  quotient
);

    import ldbr_pkg::*;

    localparam int CNT_W = $clog2(DEPTH_W + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DEPTH_W-1:0] rem_reg, rem_next;
    logic [DEPTH_W-1:0] quo_reg, quo_next;
    logic [DEPTH_W-1:0] div_reg;
    logic [DEPTH_W:0]   shifted;
    logic [DEPTH_W+1:0] trial;
    logic               fits;

    // Restoring division, one quotient bit per cycle, MSB first.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DEPTH_W-1]};
        trial    = {1'b0, shifted} - {2'b00, div_reg};
        fits     = ~trial[DEPTH_W+1];
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DEPTH_W);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? trial[DEPTH_W-1:0] : shifted[DEPTH_W-1:0];
            quo_next = {quo_reg[DEPTH_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

/* src/ldbr_front.sv */
module ldbr_front #(
    parameter int BIN_COUNT = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic [ldbr_pkg::MODE_W-1:0]         mode,
    input  logic signed [ldbr_pkg::Z_W-1:0]     view_z,
    input  logic [ldbr_pkg::RADIUS_W-1:0]       radius,
    input  logic [ldbr_pkg::IDX_W-1:0]          light_index,
    input  logic [ldbr_pkg::SEL_W-1:0]          bin_select,
    input  logic [ldbr_pkg::DEPTH_W-1:0]        bin_depth,
    input  logic                                hold,
    input  logic                                cq_full,
    output logic                                full,
    output logic                                cq_push,
    output ldbr_pkg::cmd_t                      cq_data
);

    import ldbr_pkg::*;

    localparam logic [DEPTH_W-1:0] LAST_BIN = DEPTH_W'(BIN_COUNT - 1);

    front_state_t         state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg;
    logic                 near_neg_reg, far_neg_reg;
    logic signed [Z_W+1:0] z_ext, r_ext, neg_z, near_d, far_d;
    logic [DEPTH_W-1:0]   step;
    logic [DEPTH_W-1:0]   near_q, far_q;
    logic                 near_busy, far_busy;
    logic                 accept, start;

    function automatic logic [BIN_IDX_W-1:0] to_bin(input logic neg,
                                                    input logic [DEPTH_W-1:0] q);
        logic [BIN_IDX_W-1:0] b;
        if (neg)
            b = '0;
        else if (q > LAST_BIN)
            b = LAST_BIN[BIN_IDX_W-1:0];
        else
            b = q[BIN_IDX_W-1:0];
        return b;
    endfunction

    // Near and far depth are exact 34-bit values; any non-negative one fits 32 bits.
    always_comb
    begin
        z_ext  = {{2{view_z[Z_W-1]}}, view_z};
        r_ext  = {3'b000, radius};
        neg_z  = -z_ext;
        near_d = neg_z - r_ext;
        far_d  = neg_z + r_ext;
        step   = (bin_depth == '0) ? DEPTH_W'(1) : bin_depth;
    end

    assign full   = (state_reg != F_IDLE) || cq_full || hold;
    assign accept = push && !full;
    assign start  = accept && (mode_t'(mode) == MODE_INSERT);

    ldbr_div u_div_near (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (near_d[DEPTH_W-1:0]),
        .divisor  (step),
        .busy     (near_busy),
        .quotient (near_q)
    );

    ldbr_div u_div_far (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .dividend (far_d[DEPTH_W-1:0]),
        .divisor  (step),
        .busy     (far_busy),
        .quotient (far_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                    state_next = F_DIV;
            end
            F_DIV:
            begin
                if (!near_busy && !far_busy && !cq_full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cq_push = 1'b0;
        cq_data = '{op: mode_t'(mode), lo: '0, hi: '0, idx: light_index, sel: bin_select};
        case (state_reg)
            F_IDLE:
            begin
                cq_push = accept && !start;
            end
            F_DIV:
            begin
                cq_push = !near_busy && !far_busy && !cq_full;
                cq_data = '{op: MODE_INSERT,
                            lo: to_bin(near_neg_reg, near_q),
                            hi: to_bin(far_neg_reg, far_q),
                            idx: idx_reg,
                            sel: '0};
            end
            default:
            begin
                cq_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            idx_reg      <= light_index;
            near_neg_reg <= near_d[Z_W+1];
            far_neg_reg  <= far_d[Z_W+1];
        end
    end

endmodule

/* src/ldbr_cmdq.sv */
module ldbr_cmdq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ldbr_pkg::cmd_t  wdata,
    output logic            full,
    input  logic            pop,
    output ldbr_pkg::cmd_t  rdata,
    output logic            empty
);

    import ldbr_pkg::*;

    cmd_t                  q_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] cnt_reg;
    logic                  do_push, do_pop;

    assign full    = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* src/ldbr_back.sv */
module ldbr_back #(
    parameter int BIN_COUNT = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cq_empty,
    input  ldbr_pkg::cmd_t              cq_data,
    output logic                        cq_pop,
    input  logic                        pop,
    output logic                        empty,
    output logic [ldbr_pkg::IDX_W-1:0]  min_index,
    output logic [ldbr_pkg::IDX_W-1:0]  max_index,
    output logic                        init_busy
);

    import ldbr_pkg::*;

    localparam int AW = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam logic [AW-1:0]          LAST_A   = AW'(BIN_COUNT - 1);
    localparam logic [BIN_IDX_W:0]     COUNT_W  = (BIN_IDX_W + 1)'(BIN_COUNT);

    back_state_t       state_reg, state_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              issue_reg, issue_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    cmd_t              cmd_reg, cmd_next;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_min_reg, out_min_next;
    logic [IDX_W-1:0]  out_max_reg, out_max_next;

    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    logic [IDX_W-1:0]  cur_min, cur_max, new_min, new_max;
    logic [AW-1:0]     lo_a, hi_a;
    logic              out_ready, sel_ok;

    ldbr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BIN_COUNT)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cur_min   = ram_rdata[ENTRY_W-1:IDX_W];
        cur_max   = ram_rdata[IDX_W-1:0];
        new_min   = (cmd_reg.idx < cur_min) ? cmd_reg.idx : cur_min;
        new_max   = (cmd_reg.idx > cur_max) ? cmd_reg.idx : cur_max;
        lo_a      = AW'(cq_data.lo);
        hi_a      = AW'(cmd_reg.hi);
        out_ready = !out_valid_reg || pop;
        sel_ok    = ((BIN_IDX_W + 1)'(cmd_reg.sel) < COUNT_W);
    end

    assign cq_pop    = (state_reg == B_IDLE) && !cq_empty;
    assign init_busy = (state_reg == B_INIT);
    assign empty     = !out_valid_reg;
    assign min_index = out_min_reg;
    assign max_index = out_max_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_INIT:
            begin
                if (ptr_reg == LAST_A)
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (!cq_empty)
                begin
                    case (cq_data.op)
                        MODE_CLEAR:  state_next = B_CLEAR;
                        MODE_INSERT: state_next = B_WALK;
                        default:     state_next = B_DONE;
                    endcase
                end
            end
            B_CLEAR:
            begin
                if (ptr_reg == LAST_A)
                    state_next = B_DONE;
            end
            B_WALK:
            begin
                if (!issue_reg && !pend_reg)
                    state_next = B_DONE;
            end
            B_DONE:
            begin
                if (out_ready)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg;
        ram_wdata      = BIN_EMPTY;
        ram_re         = 1'b0;
        ram_raddr      = ptr_reg;
        ptr_next       = ptr_reg;
        issue_next     = issue_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        cmd_next       = cmd_reg;
        out_valid_next = out_valid_reg && !pop;
        out_min_next   = out_min_reg;
        out_max_next   = out_max_reg;
        case (state_reg)
            B_INIT, B_CLEAR:
            begin
                ram_we   = 1'b1;
                ptr_next = (ptr_reg == LAST_A) ? '0 : ptr_reg + 1'b1;
            end
            B_IDLE:
            begin
                if (!cq_empty)
                begin
                    cmd_next   = cq_data;
                    ram_re     = (cq_data.op == MODE_READ);
                    ram_raddr  = AW'(cq_data.sel);
                    ptr_next   = (cq_data.op == MODE_INSERT) ? lo_a : '0;
                    issue_next = (cq_data.op == MODE_INSERT);
                end
            end
            B_WALK:
            begin
                // Reads run one bin ahead of the writes; addresses only rise.
                ram_re         = issue_reg;
                ram_we         = pend_reg;
                ram_waddr      = pend_addr_reg;
                ram_wdata      = {new_min, new_max};
                pend_next      = issue_reg;
                pend_addr_next = ptr_reg;
                if (issue_reg)
                begin
                    if (ptr_reg == hi_a)
                        issue_next = 1'b0;
                    else
                        ptr_next = ptr_reg + 1'b1;
                end
            end
            B_DONE:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (cmd_reg.op == MODE_READ)
                    begin
                        out_min_next = sel_ok ? cur_min : EMPTY_MIN;
                        out_max_next = sel_ok ? cur_max : EMPTY_MAX;
                    end
                    else
                    begin
                        out_min_next = '0;
                        out_max_next = '0;
                    end
                end
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            ptr_reg       <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        cmd_reg       <= cmd_next;
        out_min_reg   <= out_min_next;
        out_max_reg   <= out_max_next;
    end

endmodule

/* src/light_depth_bin_ranges.sv */
// Channel   Direction  Handshake                 Payload
// input     in         push / full               mode, view_z, radius, light_index, bin_select
// result    out        empty / pop               min_index, max_index
// config    in/out     psel, penable, pwrite     paddr, pwdata, prdata, pready
//
// An insert first passes the front end, where two bit-serial dividers find its
// near and far bins, and then walks its span of bins in the back end, one bin
// per cycle through the bin memory. A read or an unused mode goes straight from
// the queue to its result, and a clear sweeps every bin first.
// After reset the back end sweeps the memory once, and full stays high meanwhile.
// Either side may stall; the command queue lets the front end finish the next
// division while the back end walks bins or a result waits to be popped.
module light_depth_bin_ranges #(
    parameter int BIN_COUNT = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               push,
    output logic                               full,
    input  logic [ldbr_pkg::MODE_W-1:0]        mode,
    input  logic signed [ldbr_pkg::Z_W-1:0]    view_z,
    input  logic [ldbr_pkg::RADIUS_W-1:0]      radius,
    input  logic [ldbr_pkg::IDX_W-1:0]         light_index,
    input  logic [ldbr_pkg::SEL_W-1:0]         bin_select,

    output logic                               empty,
    input  logic                               pop,
    output logic [ldbr_pkg::IDX_W-1:0]         min_index,
    output logic [ldbr_pkg::IDX_W-1:0]         max_index,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [ldbr_pkg::DEPTH_W-1:0]       pwdata,
    output logic [ldbr_pkg::DEPTH_W-1:0]       prdata,
    output logic                               pready
);

    import ldbr_pkg::*;

    logic [DEPTH_W-1:0] bin_depth_reg;
    logic               cfg_wr;
    logic               cq_push, cq_pop, cq_full, cq_empty;
    cmd_t               cq_wdata, cq_rdata;
    logic               init_busy;

    // The register index is the address divided by four; only index zero exists.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_BIN_DEPTH);
    assign prdata = (paddr[2] == REG_BIN_DEPTH) ? bin_depth_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_depth_reg <= BIN_DEPTH_RESET;
        end
        else if (cfg_wr)
        begin
            bin_depth_reg <= pwdata;
        end
    end

    // The front end turns each item into a command: inserts get their bin span.
    ldbr_front #(
        .BIN_COUNT (BIN_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .mode        (mode),
        .view_z      (view_z),
        .radius      (radius),
        .light_index (light_index),
        .bin_select  (bin_select),
        .bin_depth   (bin_depth_reg),
        .hold        (init_busy),
        .cq_full     (cq_full),
        .full        (full),
        .cq_push     (cq_push),
        .cq_data     (cq_wdata)
    );

    ldbr_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .wdata (cq_wdata),
        .full  (cq_full),
        .pop   (cq_pop),
        .rdata (cq_rdata),
        .empty (cq_empty)
    );

    // The back end owns the bin memory and produces one result transfer per command.
    ldbr_back #(
        .BIN_COUNT (BIN_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cq_empty  (cq_empty),
        .cq_data   (cq_rdata),
        .cq_pop    (cq_pop),
        .pop       (pop),
        .empty     (empty),
        .min_index (min_index),
        .max_index (max_index),
        .init_busy (init_busy)
    );

endmodule

/* src/ldbr_checker.sv */
module ldbr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [ldbr_pkg::IDX_W-1:0]  min_index,
    input logic [ldbr_pkg::IDX_W-1:0]  max_index,
    input logic                        pready
);

    import ldbr_pkg::*;

    localparam logic [3:0] MAX_OUTSTANDING = 4'd5;

    logic [3:0] outstanding_reg;
    logic       in_xfer, out_xfer;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            outstanding_reg <= outstanding_reg + 1'b1;
        end
        else if (out_xfer && !in_xfer)
        begin
            outstanding_reg <= outstanding_reg - 1'b1;
        end
    end

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(min_index) && $stable(max_index)))
        else $error("waiting result changed or vanished");

    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (outstanding_reg != '0))
        else $error("result without a pending item");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= MAX_OUTSTANDING)
        else $error("more items in flight than the block can hold");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind light_depth_bin_ranges ldbr_checker u_ldbr_checker (.*);

/* test/tb.sv */
// Testbench for light_depth_bin_ranges.
//
// A driver feeds light commands (clear, insert, read, unused mode) from a queue
// that the main initial block fills. Every command that the block takes in is
// run through a local model of the bin table at once. The model's result for it
// joins a queue of expected bin ranges. A monitor pops results at random and
// compares each one with the oldest expected range. The bin depth register is
// rewritten between phases, always with nothing in flight, and read back.
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ldbr_pkg::*;

    localparam int BIN_COUNT      = 1024;
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int PHASE_ITEMS    = 257;
    localparam int IDLE_PCT       = 18;
    localparam int RX_STALL_LEN   = 400;
    localparam longint Z_MIN      = -64'sd2147483648;
    localparam longint R_MAX      = 64'sd2147483647;
    localparam logic [2:0] BIN_DEPTH_ADDR = {REG_BIN_DEPTH, 2'b00};

    // One input transfer, in the order of the block's payload ports.
    typedef struct packed {
        mode_t                      op;
        logic signed [Z_W-1:0]      z;
        logic [RADIUS_W-1:0]        r;
        logic [IDX_W-1:0]           idx;
        logic [SEL_W-1:0]           sel;
    } light_cmd_t;

    // One result transfer; the layout matches a bin table entry.
    typedef struct packed {
        logic [IDX_W-1:0] min_idx;
        logic [IDX_W-1:0] max_idx;
    } bin_range_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;

    logic                   push = 1'b0;
    logic                   full;
    logic [MODE_W-1:0]      mode = '0;
    logic signed [Z_W-1:0]  view_z = '0;
    logic [RADIUS_W-1:0]    radius = '0;
    logic [IDX_W-1:0]       light_index = '0;
    logic [SEL_W-1:0]       bin_select = '0;

    logic                   empty;
    logic                   pop = 1'b0;
    logic [IDX_W-1:0]       min_index;
    logic [IDX_W-1:0]       max_index;

    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [DEPTH_W-1:0]     pwdata = '0;
    logic [DEPTH_W-1:0]     prdata;
    logic                   pready;

    // Local model of the block: the bin table and the bin depth register.
    logic [ENTRY_W-1:0]     bin_table [BIN_COUNT];
    logic [DEPTH_W-1:0]     bin_depth_shadow = BIN_DEPTH_RESET;

    light_cmd_t             light_cmd_q[$];
    bin_range_t             expected_ranges_q[$];
    light_cmd_t             offered;
    bin_range_t             oldest_range;

    int                     cmds_accepted = 0;
    int                     results_seen = 0;
    int                     mismatch_count = 0;
    int                     rx_stall_left = 0;
    int                     cycle_count = 0;
    int                     op_count [4] = '{0, 0, 0, 0};
    int                     recent_bin = 0;

    light_depth_bin_ranges #(
        .BIN_COUNT(BIN_COUNT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .mode(mode),
        .view_z(view_z),
        .radius(radius),
        .light_index(light_index),
        .bin_select(bin_select),
        .empty(empty),
        .pop(pop),
        .min_index(min_index),
        .max_index(max_index),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Turns a depth (Q16.16, may be negative) into a bin number. Negative depths
    // land in bin 0 and anything past the table lands in the last bin.
    function automatic int depth_bin(longint depth, longint bin_step);
        longint q;
        if (depth < 0)
            return 0;
        q = depth / bin_step;
        return (q > BIN_COUNT - 1) ? BIN_COUNT - 1 : int'(q);
    endfunction

    // Applies one accepted command to the model table and returns the range
    // that the block must report for it. Only a read reports table contents;
    // every other mode reports zero for both indexes.
    function automatic bin_range_t apply_to_bins(light_cmd_t c);
        bin_range_t res;
        longint bin_step;
        longint near_d;
        longint far_d;
        int lo;
        int hi;
        res = '0;
        case (c.op)
            MODE_CLEAR:
            begin
                for (int i = 0; i < BIN_COUNT; i++)
                    bin_table[i] = BIN_EMPTY;
            end
            MODE_INSERT:
            begin
                // A bin depth of zero behaves as the smallest step.
                bin_step = (bin_depth_shadow == 0) ? 64'sd1 : longint'(bin_depth_shadow);
                near_d = -longint'($signed(c.z)) - longint'(c.r);
                far_d  = -longint'($signed(c.z)) + longint'(c.r);
                lo = depth_bin(near_d, bin_step);
                hi = depth_bin(far_d, bin_step);
                for (int i = lo; i <= hi; i++)
                begin
                    if (c.idx < bin_table[i][31:16])
                        bin_table[i][31:16] = c.idx;
                    if (c.idx > bin_table[i][15:0])
                        bin_table[i][15:0] = c.idx;
                end
            end
            MODE_READ:
            begin
                res = (c.sel < BIN_COUNT) ? bin_table[c.sel] : BIN_EMPTY;
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Builds one random command. Most inserts are well-formed lights that span
    // a few bins around a chosen bin; a few span tens of bins. Half of the reads
    // look near the last light so that they often hit filled bins. A small share
    // is raw noise in every field, which also reaches the top bits of z and radius.
    function automatic light_cmd_t random_cmd(logic [DEPTH_W-1:0] depth);
        light_cmd_t c;
        longint bin_step;
        longint zl;
        longint rl;
        int unsigned roll;
        int unsigned center_bin;
        int unsigned span;
        bin_step = (depth == 0) ? 64'sd1 : longint'(depth);
        c.op  = MODE_READ;
        c.z   = $urandom;
        c.r   = RADIUS_W'($urandom);
        c.idx = IDX_W'($urandom);
        c.sel = SEL_W'($urandom);
        roll = $urandom_range(99);
        if (roll < 4)
            c.op = mode_t'($urandom_range(3));
        else if (roll < 5)
            c.op = MODE_CLEAR;
        else if (roll < 9)
            c.op = MODE_NONE;
        else if (roll < 40)
        begin
            c.op = MODE_READ;
            if ($urandom_range(1) == 1)
                c.sel = SEL_W'(recent_bin + $urandom_range(4) - 2);
        end
        else
        begin
            c.op = MODE_INSERT;
            span = ($urandom_range(19) == 0) ? $urandom_range(40) : $urandom_range(3);
            rl = longint'(span) * bin_step;
            if ($urandom_range(3) != 0)
                rl += longint'($urandom) % bin_step;
            if ($urandom_range(9) == 0)
            begin
                // Light center behind the camera.
                zl = longint'($urandom_range(32'h7FFF_FFFF));
                recent_bin = 0;
            end
            else
            begin
                center_bin = $urandom_range(1100);
                zl = -(longint'(center_bin) * bin_step + longint'($urandom) % bin_step);
                recent_bin = (center_bin > BIN_COUNT - 1) ? BIN_COUNT - 1 : center_bin;
            end
            if (zl < Z_MIN)
                zl = Z_MIN;
            if (rl > R_MAX)
                rl = R_MAX;
            c.z = zl[31:0];
            c.r = rl[30:0];
            case ($urandom_range(15))
                0: c.idx = '0;
                1: c.idx = '1;
                default: ;
            endcase
        end
        return c;
    endfunction

    task automatic queue_cmd(input mode_t op, input logic signed [Z_W-1:0] z,
                             input logic [RADIUS_W-1:0] r, input logic [IDX_W-1:0] idx,
                             input logic [SEL_W-1:0] sel);
        light_cmd_t c;
        c.op  = op;
        c.z   = z;
        c.r   = r;
        c.idx = idx;
        c.sel = sel;
        light_cmd_q.insert(light_cmd_q.size(), c);
    endtask

    // Returns once the sender has nothing left and every expected result has
    // been popped. The sender keeps emptying its queue during the wait.
    task automatic wait_drained();
        @(negedge clk);
        while (light_cmd_q.size() != 0 || push || expected_ranges_q.size() != 0)
            @(negedge clk);
    endtask

    // Writes the bin depth register, then reads it back in a second transfer.
    task automatic set_bin_depth(input logic [DEPTH_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BIN_DEPTH_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        // The write lands on this edge; the read setup follows straight away.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== value)
        begin
            $display("%0t bin_depth readback: expected %h actual %h", $realtime, value, prdata);
            mismatch_count++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        bin_depth_shadow = value;
    endtask

    // Driver. A command stays on the ports until the block takes it. The
    // accepted command updates the model in the same step, so expectations
    // follow the exact order of acceptance. The sender idles at random, with the
    // chance set by IDLE_PCT, except over a long stretch in the middle of the run.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                expected_ranges_q.insert(expected_ranges_q.size(), apply_to_bins(offered));
                op_count[offered.op]++;
                cmds_accepted++;
            end
            if (!push || !full)
            begin
                if (light_cmd_q.size() != 0 && $urandom_range(99) >=
                    ((cmds_accepted >= 700 && cmds_accepted < 1000) ? 0 : IDLE_PCT))
                begin
                    offered = light_cmd_q.pop_front();
                    push        <= 1'b1;
                    mode        <= offered.op;
                    view_z      <= offered.z;
                    radius      <= offered.r;
                    light_index <= offered.idx;
                    bin_select  <= offered.sel;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver. Each popped result is checked field by field against
    // the oldest expectation. Twice in the run the receiver holds pop low for a
    // long stretch while the sender keeps offering, so the block backs up and
    // raises full.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                results_seen++;
                if (expected_ranges_q.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual min %h max %h",
                             $realtime, min_index, max_index);
                    mismatch_count++;
                end
                else
                begin
                    oldest_range = expected_ranges_q.pop_front();
                    if (min_index !== oldest_range.min_idx)
                    begin
                        $display("%0t min_index: expected %h actual %h",
                                 $realtime, oldest_range.min_idx, min_index);
                        mismatch_count++;
                    end
                    if (max_index !== oldest_range.max_idx)
                    begin
                        $display("%0t max_index: expected %h actual %h",
                                 $realtime, oldest_range.max_idx, max_index);
                        mismatch_count++;
                    end
                end
                if (results_seen == 150 || results_seen == 1100)
                    rx_stall_left = RX_STALL_LEN;
            end
            if (rx_stall_left > 0)
            begin
                rx_stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(99) >=
                        ((results_seen >= 700 && results_seen < 1000) ? 0 : IDLE_PCT));
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus sequence: reset, a directed set at the reset bin depth, then
    // random phases, each at a new bin depth written while the block is idle.
    initial
    begin
        logic [DEPTH_W-1:0] depth_plan [7];
        depth_plan = '{32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_4000,
                       32'h0001_0000, 32'h0003_8000, 32'h0000_0000};
        depth_plan[6] = $urandom_range(32'h0010_0000, 32'h0000_1000);

        for (int i = 0; i < BIN_COUNT; i++)
            bin_table[i] = BIN_EMPTY;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, bin depth 1.0. After reset both ends of the table read
        // empty. Then lights that touch only bin 0, that span a few inner bins,
        // that sit exactly on the last bin, one that covers every bin, and one
        // entirely behind the camera with the largest index.
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'h1234, 10'd0);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'h1234, 10'd1023);
        queue_cmd(MODE_INSERT, 32'sd0,          31'd0,          16'd5,    10'd0);
        queue_cmd(MODE_INSERT, -32'sd688128,    31'd131072,     16'd0,    10'd0);
        queue_cmd(MODE_INSERT, -32'sd327680,    31'd65536,      16'd9,    10'd0);
        queue_cmd(MODE_INSERT, 32'sh7FFF_FFFF,  31'd0,          16'hFFFF, 10'd0);
        queue_cmd(MODE_INSERT, -32'sd67043328,  31'd0,          16'd7,    10'd3);
        queue_cmd(MODE_INSERT, 32'sh8000_0000,  31'h7FFF_FFFF,  16'd1234, 10'd0);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'd0,    10'd0);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'd0,    10'd8);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'd0,    10'd5);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'd0,    10'd12);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'd0,    10'd13);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'd0,    10'd1023);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'd0,    10'd500);
        // The unused mode must leave the table alone and report zeros.
        queue_cmd(MODE_NONE,   -32'sd100000,    31'd5000,       16'd3,    10'd8);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'd0,    10'd8);
        queue_cmd(MODE_CLEAR,  32'sh5555_5555,  31'h2AAA_AAAA,  16'hAAAA, 10'h155);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'd0,    10'd0);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'd0,    10'd1023);
        queue_cmd(MODE_INSERT, -32'sd1310720,   31'd0,          16'hFFFF, 10'd0);
        queue_cmd(MODE_INSERT, -32'sd1310720,   31'd0,          16'd0,    10'd0);
        queue_cmd(MODE_READ,   32'sd0,          31'd0,          16'd0,    10'd20);
        wait_drained();

        foreach (depth_plan[p])
        begin
            // Every command yields a result, so a drained queue means idle;
            // a short margin covers the back end finishing its last step.
            repeat (16) @(posedge clk);
            set_bin_depth(depth_plan[p]);
            @(negedge clk);
            for (int n = 0; n < PHASE_ITEMS; n++)
                light_cmd_q.insert(light_cmd_q.size(), random_cmd(bin_depth_shadow));
            wait_drained();
        end

        // Give a stray result time to appear; a clear or an insert across every bin takes longest.
        repeat (BIN_COUNT + 64) @(posedge clk);

        $display("Covered %0d commands: %0d clears, %0d inserts, %0d reads, %0d unused mode.",
                 cmds_accepted, op_count[MODE_CLEAR], op_count[MODE_INSERT],
                 op_count[MODE_READ], op_count[MODE_NONE]);
        $display("Checked %0d results over %0d bin depth settings, %0d mismatches.",
                 results_seen, $size(depth_plan) + 1, mismatch_count);
        if (mismatch_count == 0 && expected_ranges_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
